FILE: sv/wfd_pkg.sv
// ----------------------------------------------------------------------------
// wfd_pkg
// Types, constants and helpers shared by the WebSocket frame decoder.
// ----------------------------------------------------------------------------
package wfd_pkg;

    // Parse queue between the header parser and the output stage
    localparam int QDepth  = 4;
    localparam int QAddrW  = $clog2(QDepth);
    localparam int QCountW = $clog2(QDepth + 1);

    // Width of the result data word (byte, opcode, fin, padded to bytes)
    localparam int MDataW = 16;

    // Header bit fields
    localparam logic [7:0] HdrFin   = 8'h80;
    localparam logic [7:0] HdrRsv   = 8'h70;
    localparam logic [7:0] HdrOp    = 8'h0F;
    localparam logic [6:0] Len7Mask = 7'h7F;
    localparam logic [6:0] Len16    = 7'd126;
    localparam logic [6:0] Len64    = 7'd127;
    localparam logic [63:0] CtrlMaxLen = 64'd125;

    // Opcodes
    localparam logic [3:0] OpCont   = 4'd0;
    localparam logic [3:0] OpBinary = 4'd2;
    localparam logic [3:0] OpClose  = 4'd8;
    localparam logic [3:0] OpPing   = 4'd9;
    localparam logic [3:0] OpPong   = 4'd10;

    typedef enum logic [3:0] {
        ST_PAYLOAD   = 4'd0,
        ST_EMPTY     = 4'd1,
        ST_RSV_BITS  = 4'd2,
        ST_BAD_OP    = 4'd3,
        ST_LEN_MSB   = 4'd4,
        ST_CTRL_FRAG = 4'd5,
        ST_CTRL_LONG = 4'd6,
        ST_DATA_FRAG = 4'd7,
        ST_CONT      = 4'd8,
        ST_UNMASKED  = 4'd9
    } t_status;

    // One request from the parser to the output stage
    typedef struct packed {
        logic [7:0] data;    // received (still masked) byte
        logic [7:0] key;     // mask key byte to apply
        logic [3:0] opcode;
        logic       fin;
        logic       fend;    // last byte of frame / empty frame
        t_status    status;
    } t_tok;

    function automatic logic f_is_ctrl(input logic [3:0] op);
        f_is_ctrl = (op == OpClose) || (op == OpPing) || (op == OpPong);
    endfunction

    function automatic logic f_is_known(input logic [3:0] op);
        f_is_known = (op <= OpBinary) || f_is_ctrl(op);
    endfunction

    // Checks once the payload length is known; ST_PAYLOAD means pass
    function automatic t_status f_len_checks(input logic [7:0] hdr,
                                             input logic       masked,
                                             input logic       too_long);
        logic fin;
        logic [3:0] op;
        fin = (hdr & HdrFin) != 8'h00;
        op  = hdr[3:0] & HdrOp[3:0];
        f_len_checks = ST_PAYLOAD;
        if (f_is_ctrl(op)) begin
            if (!fin)
                f_len_checks = ST_CTRL_FRAG;
            else if (too_long)
                f_len_checks = ST_CTRL_LONG;
            else if (!masked)
                f_len_checks = ST_UNMASKED;
        end else begin
            if (!fin)
                f_len_checks = ST_DATA_FRAG;
            else if (op == OpCont)
                f_len_checks = ST_CONT;
            else if (!masked)
                f_len_checks = ST_UNMASKED;
        end
    endfunction

endpackage

FILE: sv/wfd_front.sv
// ----------------------------------------------------------------------------
// wfd_front
// Header parser: walks header, extended length and mask key, classifies
// every byte and pushes one request per result into the queue.
// ----------------------------------------------------------------------------
module wfd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_full,
    output logic               o_ready,
    output logic               o_push,
    output wfd_pkg::t_tok      o_tok
);

    typedef enum logic [4:0] {
        PH_HDR1 = 5'b00001,
        PH_HDR2 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_MASK = 5'b01000,
        PH_DATA = 5'b10000
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [7:0]    r_hdr, n_hdr;
    logic          r_mask, n_mask;
    logic [63:0]   r_len, n_len;
    logic [2:0]    r_ext, n_ext;
    logic [31:0]   r_key, n_key;
    logic [1:0]    r_idx, n_idx;
    logic [62:0]   r_left, n_left;
    logic          r_halt, n_halt;

    logic          w_acc;
    logic [6:0]    w_len7;
    logic [63:0]   w_ext_len;
    wfd_pkg::t_status w_chk;

    assign o_ready   = !i_full;
    assign w_acc     = i_valid && o_ready && !r_halt;
    assign w_len7    = i_byte[6:0] & wfd_pkg::Len7Mask;
    assign w_ext_len = {r_len[55:0], i_byte};

    always_comb begin
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_mask  = r_mask;
        n_len   = r_len;
        n_ext   = r_ext;
        n_key   = r_key;
        n_idx   = r_idx;
        n_left  = r_left;
        n_halt  = r_halt;
        w_chk   = wfd_pkg::ST_PAYLOAD;
        o_push  = 1'b0;
        o_tok        = '0;
        o_tok.opcode = r_hdr[3:0];
        o_tok.fin    = r_hdr[7];
        o_tok.status = wfd_pkg::ST_PAYLOAD;

        if (w_acc) begin
            case (r_phase)
                PH_HDR2: begin
                    n_mask = i_byte[7];
                    if ((r_hdr & wfd_pkg::HdrRsv) != 8'h00) begin
                        o_push       = 1'b1;
                        o_tok.status = wfd_pkg::ST_RSV_BITS;
                        n_halt       = 1'b1;
                    end else if (!wfd_pkg::f_is_known(r_hdr[3:0])) begin
                        o_push       = 1'b1;
                        o_tok.status = wfd_pkg::ST_BAD_OP;
                        n_halt       = 1'b1;
                    end else if (w_len7 == wfd_pkg::Len16) begin
                        n_len   = '0;
                        n_ext   = 3'd1;
                        n_phase = PH_EXT;
                    end else if (w_len7 == wfd_pkg::Len64) begin
                        n_len   = '0;
                        n_ext   = 3'd7;
                        n_phase = PH_EXT;
                    end else begin
                        // short length never exceeds the control limit
                        n_len = {57'd0, w_len7};
                        w_chk = wfd_pkg::f_len_checks(r_hdr, i_byte[7], 1'b0);
                        if (w_chk != wfd_pkg::ST_PAYLOAD) begin
                            o_push       = 1'b1;
                            o_tok.status = w_chk;
                            n_halt       = 1'b1;
                        end else begin
                            n_left  = {56'd0, w_len7};
                            n_idx   = 2'd0;
                            n_phase = PH_MASK;
                        end
                    end
                end
                PH_EXT: begin
                    n_len = w_ext_len;
                    if (r_ext != 3'd0) begin
                        n_ext = r_ext - 3'd1;
                    end else if (w_ext_len[63]) begin
                        o_push       = 1'b1;
                        o_tok.status = wfd_pkg::ST_LEN_MSB;
                        n_halt       = 1'b1;
                    end else begin
                        w_chk = wfd_pkg::f_len_checks(r_hdr, r_mask,
                                    w_ext_len > wfd_pkg::CtrlMaxLen);
                        if (w_chk != wfd_pkg::ST_PAYLOAD) begin
                            o_push       = 1'b1;
                            o_tok.status = w_chk;
                            n_halt       = 1'b1;
                        end else begin
                            n_left  = w_ext_len[62:0];
                            n_idx   = 2'd0;
                            n_phase = PH_MASK;
                        end
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], i_byte};
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        if (r_left == 63'd0) begin
                            o_push       = 1'b1;
                            o_tok.fend   = 1'b1;
                            o_tok.status = wfd_pkg::ST_EMPTY;
                            n_phase      = PH_HDR1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    // key byte 0 sits in bits 31..24
                    o_push     = 1'b1;
                    o_tok.data = i_byte;
                    o_tok.key  = r_key[{~r_idx, 3'b000} +: 8];
                    o_tok.fend = (r_left == 63'd1);
                    n_idx      = r_idx + 2'd1;
                    n_left     = r_left - 63'd1;
                    if (r_left == 63'd1)
                        n_phase = PH_HDR1;
                end
                default: begin
                    n_hdr   = i_byte;
                    n_phase = PH_HDR2;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR1;
            r_idx   <= 2'd0;
            r_halt  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_halt  <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr  <= n_hdr;
        r_mask <= n_mask;
        r_len  <= n_len;
        r_ext  <= n_ext;
        r_key  <= n_key;
        r_left <= n_left;
    end

endmodule

FILE: sv/wfd_fifo.sv
// ----------------------------------------------------------------------------
// wfd_fifo
// Short request queue between parser and output stage.
// ----------------------------------------------------------------------------
module wfd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wfd_pkg::t_tok i_tok,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output wfd_pkg::t_tok o_tok
);

    wfd_pkg::t_tok                 r_mem [wfd_pkg::QDepth];
    logic [wfd_pkg::QAddrW-1:0]    r_wr, n_wr;
    logic [wfd_pkg::QAddrW-1:0]    r_rd, n_rd;
    logic [wfd_pkg::QCountW-1:0]   r_cnt, n_cnt;
    logic                          w_wr_en;
    logic                          w_rd_en;

    assign o_full  = (r_cnt == wfd_pkg::QCountW'(wfd_pkg::QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_tok   = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;

    always_comb begin
        n_wr  = w_wr_en ? r_wr + 1'b1 : r_wr;
        n_rd  = w_rd_en ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (w_wr_en && !w_rd_en)
            n_cnt = r_cnt + 1'b1;
        else if (!w_wr_en && w_rd_en)
            n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en)
            r_mem[r_wr] <= i_tok;
    end

endmodule

FILE: sv/wfd_back.sv
// ----------------------------------------------------------------------------
// wfd_back
// Output stage: unmasks the payload byte and holds the result register.
// ----------------------------------------------------------------------------
module wfd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  wfd_pkg::t_tok              i_tok,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [wfd_pkg::MDataW-1:0] o_data,
    output logic                       o_last,
    output logic [3:0]                 o_user
);

    logic                       r_valid;
    logic [wfd_pkg::MDataW-1:0] r_data, n_data;
    logic                       r_last;
    logic [3:0]                 r_user;

    // load whenever the register is free or being drained
    assign o_pop = !i_empty && (!r_valid || i_ready);

    assign n_data = {3'd0, i_tok.fin, i_tok.opcode, i_tok.data ^ i_tok.key};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
            r_last <= i_tok.fend;
            r_user <= i_tok.status;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_user  = r_user;

endmodule

FILE: sv/websocket_frame_decoder.sv
// ----------------------------------------------------------------------------
// websocket_frame_decoder
// Client-to-server WebSocket frame parser with payload unmasking.
// ----------------------------------------------------------------------------
// Usage
//  - s_* : one received stream byte per request (s_tdata[7:0]).
//  - m_* : one result per request. m_tdata = out_byte [7:0], frame_opcode
//    [11:8], final_flag [12], zero pad. m_tlast marks the frame's last
//    payload byte or an empty frame. m_tuser is the status code.
//  - Header, extended length and mask key bytes give no result; each
//    payload byte gives one unmasked byte; a zero-length frame gives one
//    empty-frame result once its key is in.
//  - Protocol errors give one error result, then the parser halts and
//    silently swallows bytes until reset.
//  - Throughput: one byte per cycle while the queue is not full.
//  - An accepted byte is written into the queue, then loaded into the
//    output register once that register is free or being drained.
//  - Reset (sync, active low): parser back to first header byte, queue
//    empty, no result pending.
//  - If m_tready stays low the 4-deep queue plus the output register
//    absorb results, then s_tready drops until the sink drains.
// ----------------------------------------------------------------------------
module websocket_frame_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [wfd_pkg::MDataW-1:0] m_tdata,   // [7:0] out_byte,
                                                  // [11:8] frame_opcode,
                                                  // [12] final_flag
    output logic                       m_tlast,   // frame_end
    output logic [3:0]                 m_tuser    // [3:0] status
);

    wfd_pkg::t_tok w_push_tok;
    wfd_pkg::t_tok w_head_tok;
    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;

    // front: byte classification and header state
    wfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_byte  (s_tdata),
        .i_full  (w_full),
        .o_ready (s_tready),
        .o_push  (w_push),
        .o_tok   (w_push_tok)
    );

    // decoupling queue
    wfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tok   (w_push_tok),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_tok   (w_head_tok)
    );

    // back: unmask and present the result
    wfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_tok   (w_head_tok),
        .o_pop   (w_pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (m_tdata),
        .o_last  (m_tlast),
        .o_user  (m_tuser)
    );

    // queue must never be pushed while full
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("request pushed into full queue");

    // error results never carry end of frame
    a_err_no_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser != wfd_pkg::ST_PAYLOAD && m_tuser != wfd_pkg::ST_EMPTY)
        |-> !m_tlast)
        else $error("error result flagged as frame end");

    // only payload results carry a data byte
    a_zero_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser != wfd_pkg::ST_PAYLOAD) |-> (m_tdata[7:0] == 8'h00))
        else $error("non-payload result with data byte");

    // an empty-frame result always ends the frame
    a_empty_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == wfd_pkg::ST_EMPTY) |-> m_tlast)
        else $error("empty frame without frame end");

endmodule
